>>> rtl/mar_pkg.sv
// Shared types and codes for the MMIO address range matcher.
// Holds field widths, request and response structs, action and status codes.
// No dependencies; every other file imports this package.
package mar_pkg;

    // Default size of the range table.
    localparam int MAR_ENTRIES = 16;

    // Field widths.
    localparam int ACT_W    = 2;
    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 32;
    localparam int MODE_W   = 2;
    localparam int COMP_W   = 4;
    localparam int STATUS_W = 3;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    typedef logic [ACT_W-1:0]    action_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request kinds.
    localparam action_t ACT_REGISTER = 2'd0;
    localparam action_t ACT_READ     = 2'd1;
    localparam action_t ACT_WRITE    = 2'd2;

    // Response status codes.
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_OVERLAP = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_NORANGE = 3'd3;
    localparam status_t ST_DENIED  = 3'd4;
    localparam status_t ST_ZEROLEN = 3'd5;

    // Permission bits within a range's mode.
    localparam int MODE_READ_BIT  = 0;
    localparam int MODE_WRITE_BIT = 1;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    length;
        logic [MODE_W-1:0]   mode;
        logic [COMP_W-1:0]   component_id;
    } mar_req_t;

    typedef struct packed {
        status_t             status;
        logic [COMP_W-1:0]   matched_component;
        logic [LEN_W-1:0]    offset;
    } mar_rsp_t;

    // Per-entry comparison result.
    typedef struct packed {
        logic                contain;
        logic                clash;
        logic [LEN_W-1:0]    offset;
    } lane_res_t;

endpackage

>>> rtl/mar_lane.sv
// Compares one request against one stored range: containment and overlap.
// Depends on mar_pkg for widths and the lane result struct.
module mar_lane (
    input  logic                        entry_valid,
    input  logic [mar_pkg::ADDR_W-1:0]  entry_base,
    input  logic [mar_pkg::LEN_W-1:0]   entry_length,
    input  logic [mar_pkg::ADDR_W-1:0]  req_address,
    input  logic [mar_pkg::LEN_W-1:0]   req_length,
    input  logic [mar_pkg::ADDR_W:0]    req_end,
    output mar_pkg::lane_res_t          res
);
    import mar_pkg::*;

    logic [ADDR_W:0] diff;
    logic [LEN_W:0]  slack;
    logic [ADDR_W:0] entry_end;
    logic            fits;

    // Distance of the access from the base and room left in the range.
    assign diff      = {1'b0, req_address} - {1'b0, entry_base};
    assign slack     = {1'b0, entry_length} - {1'b0, req_length};
    assign entry_end = {1'b0, entry_base} + {{(ADDR_W-LEN_W+1){1'b0}}, entry_length};

    // The access lies wholly inside when the base is not above it, the range is
    // long enough, and the distance does not exceed the spare length.
    assign fits = !diff[ADDR_W] && !slack[LEN_W]
                  && (diff[ADDR_W-1:LEN_W] == '0)
                  && (diff[LEN_W-1:0] <= slack[LEN_W-1:0]);

    always_comb begin
        res.contain = entry_valid && fits;
        res.clash   = entry_valid && ({1'b0, req_address} < entry_end)
                      && ({1'b0, entry_base} < req_end);
        res.offset  = diff[LEN_W-1:0];
    end

endmodule

>>> rtl/mar_table.sv
// Range table: stored entries, one compare lane per entry, and the decision
// logic that classifies a request and adds new ranges. Uses mar_pkg, mar_lane.
module mar_table #(
    parameter int ENTRIES = mar_pkg::MAR_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              commit,
    input  mar_pkg::mar_req_t req,
    output mar_pkg::mar_rsp_t rsp
);
    import mar_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] valid_reg;
    logic [ADDR_W-1:0]  base_reg   [ENTRIES];
    logic [LEN_W-1:0]   length_reg [ENTRIES];
    logic [MODE_W-1:0]  mode_reg   [ENTRIES];
    logic [COMP_W-1:0]  owner_reg  [ENTRIES];

    lane_res_t          lane [ENTRIES];
    logic [ADDR_W:0]    req_end;
    logic               any_clash;
    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               do_write;
    logic [MODE_W-1:0]  hit_mode;

    // End of the request range, kept at full precision so it never wraps.
    assign req_end = {1'b0, req.address} + {{(ADDR_W-LEN_W+1){1'b0}}, req.length};

    // One comparator lane per stored entry.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        mar_lane u_lane (
            .entry_valid  (valid_reg[g]),
            .entry_base   (base_reg[g]),
            .entry_length (length_reg[g]),
            .req_address  (req.address),
            .req_length   (req.length),
            .req_end      (req_end),
            .res          (lane[g])
        );
    end

    // Lowest containing entry, lowest free slot, and any overlap.
    always_comb begin
        any_clash  = 1'b0;
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (lane[i].clash) begin
                any_clash = 1'b1;
            end
            if (lane[i].contain) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign hit_mode = mode_reg[hit_idx];

    // Classify the request.
    always_comb begin
        rsp.status            = ST_NORANGE;
        rsp.matched_component = '0;
        rsp.offset            = '0;
        do_write              = 1'b0;
        case (req.action)
            ACT_REGISTER: begin
                if (req.length == '0) begin
                    rsp.status = ST_ZEROLEN;
                end else if (any_clash) begin
                    rsp.status = ST_OVERLAP;
                end else if (!free_found) begin
                    rsp.status = ST_FULL;
                end else begin
                    rsp.status = ST_OK;
                    do_write   = 1'b1;
                end
            end
            ACT_READ, ACT_WRITE: begin
                if (req.length == '0) begin
                    rsp.status = ST_ZEROLEN;
                end else if (!hit_found) begin
                    rsp.status = ST_NORANGE;
                end else if ((req.action == ACT_READ && !hit_mode[MODE_READ_BIT])
                             || (req.action == ACT_WRITE && !hit_mode[MODE_WRITE_BIT])) begin
                    rsp.status = ST_DENIED;
                end else begin
                    rsp.status            = ST_OK;
                    rsp.matched_component = owner_reg[hit_idx];
                    rsp.offset            = lane[hit_idx].offset;
                end
            end
            default: begin
                rsp.status = ST_NORANGE;
            end
        endcase
    end

    // Valid bits are cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (commit && do_write) begin
            valid_reg[free_idx] <= 1'b1;
        end
    end

    // Range contents need no reset; they are read only behind a valid bit.
    always_ff @(posedge aclk) begin
        if (commit && do_write) begin
            base_reg[free_idx]   <= req.address;
            length_reg[free_idx] <= req.length;
            mode_reg[free_idx]   <= req.mode;
            owner_reg[free_idx]  <= req.component_id;
        end
    end

endmodule

>>> rtl/mmio_address_range_matcher.sv
// Top level of the MMIO address range matcher: stream ports, input register
// and result register around mar_table. Uses mar_pkg and mar_table.

// The block takes one request per clock while the result side is not held, and
// returns one response for each, in order: a request is first held in the input
// register, then makes a single pass through ENTRIES parallel compare lanes into the
// result register. A register request that succeeds is visible to the very
// next request. There is no clearing pass after reset; the table starts empty.
// When m_tready is low, the result register holds and the input register fills,
// after which s_tready drops until the result is taken.
module mmio_address_range_matcher #(
    parameter int ENTRIES = mar_pkg::MAR_ENTRIES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Requests.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // address[63:0], length[95:64], mode[97:96], component_id[101:98], zero pad
    input  logic [mar_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [mar_pkg::ACT_W-1:0]       s_tuser,
    // Responses.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // matched_component[3:0], offset[35:4], zero pad
    output logic [mar_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[2:0]
    output logic [mar_pkg::STATUS_W-1:0]    m_tuser
);
    import mar_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    mar_req_t in_req_reg;
    mar_req_t in_req_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    mar_rsp_t out_rsp_reg;
    mar_rsp_t rsp;
    logic     advance;
    logic     s_fire;

    // A request moves to the result register when that register is free
    // or is being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Unpack the incoming request.
    always_comb begin
        in_req_next.action       = s_tuser;
        in_req_next.address      = s_tdata[63:0];
        in_req_next.length       = s_tdata[95:64];
        in_req_next.mode         = s_tdata[97:96];
        in_req_next.component_id = s_tdata[101:98];
    end

    // Stage occupancy.
    always_comb begin
        in_valid_next  = s_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg <= in_req_next;
        end
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    // Table lookup and update for the request in the input register.
    mar_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    // Pack the response.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rsp_reg.status;
    assign m_tdata  = {{(M_TDATA_W-LEN_W-COMP_W){1'b0}},
                       out_rsp_reg.offset, out_rsp_reg.matched_component};

endmodule

>>> test/testbench.sv
// Self-checking testbench for mmio_address_range_matcher.
// Keeps a shadow range table that predicts every response and checks each one in order.
// Depends on mar_pkg and the matcher RTL only.
module testbench;
    import mar_pkg::*;

    // Action code with no meaning; the block must answer it with no range.
    localparam action_t ACT_UNUSED = 2'd3;

    // Permission settings for a range.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'b00;
    localparam logic [MODE_W-1:0] MODE_RO   = 2'b01;
    localparam logic [MODE_W-1:0] MODE_WO   = 2'b10;
    localparam logic [MODE_W-1:0] MODE_RW   = 2'b11;

    // Mismatch lines beyond this count are counted but not printed.
    localparam int REPORT_LIMIT = 100;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // address[63:0], length[95:64], mode[97:96], component_id[101:98], zero pad
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // action[1:0]
    logic [ACT_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // matched_component[3:0], offset[35:4], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    // status[2:0]
    logic [STATUS_W-1:0]   m_tuser;

    // Shadow copy of the range table.
    bit                    tbl_valid [MAR_ENTRIES] = '{default: 1'b0};
    logic [ADDR_W-1:0]     tbl_base  [MAR_ENTRIES] = '{default: '0};
    logic [LEN_W-1:0]      tbl_len   [MAR_ENTRIES] = '{default: '0};
    logic [MODE_W-1:0]     tbl_mode  [MAR_ENTRIES] = '{default: '0};
    logic [COMP_W-1:0]     tbl_owner [MAR_ENTRIES] = '{default: '0};

    // Responses owed by the block, oldest first.
    mar_rsp_t              pending_rsp [$];
    mar_rsp_t              rx_expected;

    int                    mismatch_count = 0;
    int                    holdoff_cycles = 0;
    int                    tx_calm_left   = 0;
    int                    rx_idle_left   = 0;
    int                    rx_calm_left   = 0;
    int                    rx_pick;

    mmio_address_range_matcher #(
        .ENTRIES (MAR_ENTRIES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // True when x lies below start + size, the sum taken without wrapping.
    function automatic bit below_end_of(logic [ADDR_W-1:0] x, logic [ADDR_W-1:0] start,
                                        logic [LEN_W-1:0] size);
        logic [ADDR_W:0] end_sum;
        end_sum = {1'b0, start} + {{(ADDR_W-LEN_W+1){1'b0}}, size};
        return {1'b0, x} < end_sum;
    endfunction

    // Work out the response to one request and apply any table update it makes.
    function automatic mar_rsp_t resolve_request(mar_req_t req);
        mar_rsp_t          rsp;
        int                slot;
        int                hit;
        bit                clash;
        logic [ADDR_W-1:0] delta;
        rsp        = '0;
        rsp.status = ST_NORANGE;
        slot       = -1;
        hit        = -1;
        clash      = 1'b0;
        if (req.action == ACT_REGISTER) begin
            if (req.length == '0) begin
                rsp.status = ST_ZEROLEN;
            end else begin
                // Any intersection wins over a full table.
                for (int i = 0; i < MAR_ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (below_end_of(req.address, tbl_base[i], tbl_len[i]) &&
                            below_end_of(tbl_base[i], req.address, req.length))
                            clash = 1'b1;
                    end else if (slot < 0) begin
                        slot = i;
                    end
                end
                if (clash) begin
                    rsp.status = ST_OVERLAP;
                end else if (slot < 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    tbl_valid[slot] = 1'b1;
                    tbl_base[slot]  = req.address;
                    tbl_len[slot]   = req.length;
                    tbl_mode[slot]  = req.mode;
                    tbl_owner[slot] = req.component_id;
                    rsp.status      = ST_OK;
                end
            end
        end else if (req.action == ACT_READ || req.action == ACT_WRITE) begin
            if (req.length == '0) begin
                rsp.status = ST_ZEROLEN;
            end else begin
                // The first entry that holds the whole access answers it.
                for (int i = 0; i < MAR_ENTRIES && hit < 0; i++) begin
                    delta = req.address - tbl_base[i];
                    if (tbl_valid[i] && req.address >= tbl_base[i] &&
                        tbl_len[i] >= req.length &&
                        delta <= {{(ADDR_W-LEN_W){1'b0}}, tbl_len[i] - req.length})
                        hit = i;
                end
                if (hit < 0) begin
                    rsp.status = ST_NORANGE;
                end else if (!tbl_mode[hit][(req.action == ACT_READ) ?
                                            MODE_READ_BIT : MODE_WRITE_BIT]) begin
                    rsp.status = ST_DENIED;
                end else begin
                    delta                 = req.address - tbl_base[hit];
                    rsp.status            = ST_OK;
                    rsp.matched_component = tbl_owner[hit];
                    rsp.offset            = delta[LEN_W-1:0];
                end
            end
        end
        return rsp;
    endfunction

    function automatic mar_req_t mk_req(action_t action, logic [ADDR_W-1:0] address,
                                        logic [LEN_W-1:0] length,
                                        logic [MODE_W-1:0] mode = MODE_NONE,
                                        logic [COMP_W-1:0] component_id = '0);
        mar_req_t req;
        req.action       = action;
        req.address      = address;
        req.length       = length;
        req.mode         = mode;
        req.component_id = component_id;
        return req;
    endfunction

    // Index of a random live entry, or -1 while the table is empty.
    function automatic int pick_live_entry();
        int live [$];
        for (int i = 0; i < MAR_ENTRIES; i++)
            if (tbl_valid[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Mostly lookups aimed at live ranges, some registrations, the rest noise.
    function automatic mar_req_t random_mar_request();
        mar_req_t         req;
        int               kind;
        int               k;
        logic [LEN_W-1:0] off;
        logic [LEN_W-1:0] room;
        req.action       = action_t'($urandom_range(0, 3));
        req.address      = {$urandom, $urandom};
        req.length       = $urandom;
        req.mode         = MODE_W'($urandom_range(0, 3));
        req.component_id = COMP_W'($urandom_range(0, 15));
        kind             = $urandom_range(0, 99);
        k                = pick_live_entry();
        if (kind < 12) begin
            req.action = ACT_REGISTER;
            if ($urandom_range(0, 1) == 0)
                req.length = $urandom_range(1, 4096);
            if (k >= 0 && $urandom_range(0, 3) == 0)
                req.address = tbl_base[k] + $urandom_range(0, tbl_len[k] - 1);
            if ($urandom_range(0, 19) == 0)
                req.length = '0;
        end else if (kind < 88 && k >= 0) begin
            req.action  = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
            off         = $urandom_range(0, tbl_len[k] - 1);
            room        = tbl_len[k] - off;
            req.address = tbl_base[k] + off;
            case ($urandom_range(0, 7))
                0: begin
                    req.length = $urandom_range(1, room);
                end
                1: begin
                    // Runs past the end of the range.
                    req.length = (room < 32'hFFFF_FFF0) ? room + $urandom_range(1, 8) : room;
                end
                2: begin
                    // Starts just below the base.
                    req.address = tbl_base[k] - $urandom_range(1, 8);
                    req.length  = $urandom_range(1, 16);
                end
                default: begin
                    req.length = $urandom_range(1, (room < 16) ? room : 16);
                end
            endcase
        end else if ($urandom_range(0, 9) == 0) begin
            req.length = '0;
        end
        return req;
    endfunction

    // Sender idle time: mostly none, some short, a few long, with calm stretches.
    function automatic int pick_gap();
        int r;
        if (tx_calm_left > 0) begin
            tx_calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            tx_calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one request after an optional gap and log its response once accepted.
    task automatic send_request(input mar_req_t req, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.action;
        s_tdata  <= {2'b00, req.component_id, req.mode, req.length, req.address};
        do @(posedge aclk); while (!s_tready);
        pending_rsp.push_back(resolve_request(req));
    endtask

    // Response side: check each accepted response, then pick the next ready level.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                rx_expected = pending_rsp.pop_front();
                if (m_tuser !== rx_expected.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, rx_expected.status));
                if (m_tdata[COMP_W-1:0] !== rx_expected.matched_component)
                    report_mismatch($sformatf("component %0d, expected %0d",
                                              m_tdata[COMP_W-1:0],
                                              rx_expected.matched_component));
                if (m_tdata[COMP_W +: LEN_W] !== rx_expected.offset)
                    report_mismatch($sformatf("offset 0x%h, expected 0x%h",
                                              m_tdata[COMP_W +: LEN_W], rx_expected.offset));
            end
        end
        if (holdoff_cycles > 0) begin
            m_tready <= 1'b0;
            holdoff_cycles--;
        end else if (rx_idle_left > 0) begin
            m_tready <= 1'b0;
            rx_idle_left--;
        end else begin
            m_tready <= 1'b1;
            if (rx_calm_left > 0) begin
                rx_calm_left--;
            end else begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 3)
                    rx_calm_left = $urandom_range(30, 100);
                else if (rx_pick < 15)
                    rx_idle_left = $urandom_range(1, 3);
                else if (rx_pick < 17)
                    rx_idle_left = $urandom_range(10, 40);
            end
        end
    end

    // Registration rules: zero length, overlap, adjacency, ranges reaching the top.
    task automatic test_register_rules();
        send_request(mk_req(ACT_REGISTER, 64'h0, 32'h100, MODE_RW, 4'd1), pick_gap());
        send_request(mk_req(ACT_REGISTER, 64'h80, 32'h0, MODE_RW, 4'd3), pick_gap());
        send_request(mk_req(ACT_REGISTER, 64'hFF, 32'h2, MODE_RW, 4'd3), pick_gap());
        send_request(mk_req(ACT_REGISTER, 64'h100, 32'h100, MODE_RO, 4'd2), pick_gap());
        send_request(mk_req(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, MODE_WO,
                            4'd15), pick_gap());
        send_request(mk_req(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1, MODE_RW, 4'd4),
                     pick_gap());
        send_request(mk_req(ACT_REGISTER, 64'h1_0000, 32'h1, MODE_NONE, 4'd0), pick_gap());
        send_request(mk_req(ACT_REGISTER, 64'h1_0000_0000, 32'hFFFF_FFFF, MODE_RW, 4'd7),
                     pick_gap());
    endtask

    // Lookups: hits, straddles, denials, zero size, the top of the space, bad action.
    task automatic test_lookups();
        send_request(mk_req(ACT_READ, 64'h0, 32'h1), pick_gap());
        send_request(mk_req(ACT_WRITE, 64'hFF, 32'h1), pick_gap());
        send_request(mk_req(ACT_READ, 64'hFF, 32'h2), pick_gap());
        send_request(mk_req(ACT_READ, 64'h180, 32'h80), pick_gap());
        send_request(mk_req(ACT_WRITE, 64'h180, 32'h4), pick_gap());
        send_request(mk_req(ACT_READ, 64'h180, 32'h0), pick_gap());
        send_request(mk_req(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1), pick_gap());
        send_request(mk_req(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FF00, 32'h101), pick_gap());
        send_request(mk_req(ACT_READ, 64'hFFFF_FFFF_FFFF_FFF0, 32'h4), pick_gap());
        send_request(mk_req(ACT_READ, 64'h1_0000, 32'h1), pick_gap());
        send_request(mk_req(ACT_WRITE, 64'h1_0000, 32'h1), pick_gap());
        send_request(mk_req(ACT_WRITE, 64'h1_FFFF_FFFE, 32'h1), pick_gap());
        send_request(mk_req(ACT_READ, 64'h1_0000_0000, 32'hFFFF_FFFF), pick_gap());
        send_request(mk_req(ACT_UNUSED, 64'h0, 32'h4, MODE_RW, 4'd9), pick_gap());
        send_request(mk_req(ACT_READ, 64'h5000, 32'h4), pick_gap());
    endtask

    // Response side holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        holdoff_cycles = 60;
        repeat (24) send_request(random_mar_request(), 0);
    endtask

    // Random traffic; the table fills along the way and later registrations bounce.
    task automatic test_random_traffic();
        repeat (600) send_request(random_mar_request(), pick_gap());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_rules();
        test_lookups();
        test_backpressure();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pending_rsp.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> mmio_address_range_matcher.f
rtl/mar_pkg.sv
rtl/mar_lane.sv
rtl/mar_table.sv
rtl/mmio_address_range_matcher.sv
test/testbench.sv
